@@ rtl/core/hll_pkg.sv @@
// Shared types, constants and a helper function for the HyperLogLog register update block.
package hll_pkg;

    localparam int DEFAULT_MAX_PRECISION = 14;
    localparam int PRECISION_RESET       = 14;
    localparam int MIN_PRECISION         = 4;
    localparam int QUEUE_DEPTH           = 4;

    localparam int KEY_W       = 64;
    localparam int INDEX_W     = 14;
    localparam int RANK_W      = 6;
    localparam int BIN_W       = 6;
    localparam int BIN_COUNT_W = 15;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int MIXER_W     = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_PRECISION = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIXER     = 1'b1;

    localparam logic [MIXER_W-1:0] MIX_MURMUR = 2'd0;
    localparam logic [MIXER_W-1:0] MIX_WANG   = 2'd1;

    localparam logic [63:0] MURMUR_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MURMUR_C2 = 64'hc4ceb9fe1a85ec53;
    localparam logic [63:0] RAN_MUL1  = 64'd3935559000370003845;
    localparam logic [63:0] RAN_ADD   = 64'd2691343689449507681;
    localparam logic [63:0] RAN_MUL2  = 64'd4768777513237032717;

    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_MERGE    = 2'd1,
        CMD_READ_REG = 2'd2,
        CMD_READ_BIN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_UPDATE   = 2'd0,
        OP_READ_REG = 2'd1,
        OP_READ_BIN = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [RANK_W-1:0] rank;
        logic [BIN_W-1:0]  bin;
    } op_t;

    typedef struct packed {
        logic [BIN_COUNT_W-1:0] bin_count;
        logic                   updated;
        logic [RANK_W-1:0]      rank_out;
        logic [INDEX_W-1:0]     reg_index;
    } result_t;

    function automatic logic [3:0] lzc8(input logic [7:0] v);
        logic [3:0] n;
        logic       run;
        n   = '0;
        run = 1'b1;
        for (int i = 7; i >= 0; i--)
        begin
            if (run && !v[i])
            begin
                n = n + 4'd1;
            end
            else
            begin
                run = 1'b0;
            end
        end
        return n;
    endfunction

endpackage

@@ rtl/core/hll_front.sv @@
// Front end: accepts beats, runs the selected key mixer and works out slot and rank.
module hll_front #(
    parameter int MAX_PRECISION = hll_pkg::DEFAULT_MAX_PRECISION
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  hll_pkg::cmd_t                        command,
    input  logic [hll_pkg::KEY_W-1:0]            key,
    input  logic [hll_pkg::INDEX_W-1:0]          index_in,
    input  logic [hll_pkg::RANK_W-1:0]           rank_in,
    input  logic [hll_pkg::BIN_W-1:0]            bin,
    input  logic [$clog2(MAX_PRECISION+1)-1:0]  precision,
    input  logic [hll_pkg::MIXER_W-1:0]          mixer_select,
    input  logic                                 clearing,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output hll_pkg::op_t                         push_op,
    output logic [MAX_PRECISION-1:0]             push_slot
);
    import hll_pkg::*;

    localparam int SLOT_W = MAX_PRECISION;

    typedef enum logic [2:0] {
        F_IDLE,
        F_HASH,
        F_LZC1,
        F_LZC2,
        F_PUSH
    } fstate_t;

    typedef enum logic [2:0] {
        U_XSR,
        U_XSL,
        U_MUL,
        U_ADDC,
        U_W3_8,
        U_W2_4,
        U_W31,
        U_DONE
    } uop_t;

    fstate_t           state_reg;
    logic [63:0]       k_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       rest_reg;
    logic [3:0]        step_reg;
    logic [1:0]        ph_reg;
    logic [7:0][3:0]   chunk_reg;
    logic [7:0][3:0]   chunk_next;
    op_t               op_reg;
    logic [SLOT_W-1:0] slot_reg;

    uop_t              uop;
    logic [5:0]        sh;
    logic [63:0]       cst;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic [63:0]       prod;
    logic [6:0]        lz_sum;
    logic              lz_run;
    logic [SLOT_W-1:0] pmask;
    logic [SLOT_W-1:0] idx_masked;
    logic [6:0]        rank_cap;
    logic [6:0]        rank_wide;
    logic [RANK_W-1:0] rank_clamped;
    logic [63:0]       k_load;

    always_comb
    begin
        uop = U_DONE;
        sh  = '0;
        cst = '0;
        if (mixer_select == MIX_MURMUR)
        begin
            unique case (step_reg)
                4'd0:    begin uop = U_XSR; sh = 6'd33; end
                4'd1:    begin uop = U_MUL; cst = MURMUR_C1; end
                4'd2:    begin uop = U_XSR; sh = 6'd33; end
                4'd3:    begin uop = U_MUL; cst = MURMUR_C2; end
                4'd4:    begin uop = U_XSR; sh = 6'd33; end
                default: uop = U_DONE;
            endcase
        end
        else if (mixer_select == MIX_WANG)
        begin
            unique case (step_reg)
                4'd0:    begin uop = U_XSR; sh = 6'd24; end
                4'd1:    uop = U_W3_8;
                4'd2:    begin uop = U_XSR; sh = 6'd14; end
                4'd3:    uop = U_W2_4;
                4'd4:    begin uop = U_XSR; sh = 6'd28; end
                4'd5:    uop = U_W31;
                default: uop = U_DONE;
            endcase
        end
        else
        begin
            unique case (step_reg)
                4'd0:    begin uop = U_MUL; cst = RAN_MUL1; end
                4'd1:    begin uop = U_ADDC; cst = RAN_ADD; end
                4'd2:    begin uop = U_XSR; sh = 6'd21; end
                4'd3:    begin uop = U_XSL; sh = 6'd37; end
                4'd4:    begin uop = U_XSR; sh = 6'd4; end
                4'd5:    begin uop = U_MUL; cst = RAN_MUL2; end
                4'd6:    begin uop = U_XSL; sh = 6'd20; end
                4'd7:    begin uop = U_XSR; sh = 6'd41; end
                4'd8:    begin uop = U_XSL; sh = 6'd5; end
                default: uop = U_DONE;
            endcase
        end
    end

    always_comb
    begin
        unique case (ph_reg)
            2'd0:    begin mul_a = k_reg[31:0];  mul_b = cst[31:0];  end
            2'd1:    begin mul_a = k_reg[63:32]; mul_b = cst[31:0];  end
            default: begin mul_a = k_reg[31:0];  mul_b = cst[63:32]; end
        endcase
        prod = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            chunk_next[c] = lzc8(rest_reg[c*8 +: 8]);
        end
    end

    always_comb
    begin
        lz_sum = '0;
        lz_run = 1'b1;
        for (int c = 7; c >= 0; c--)
        begin
            if (lz_run)
            begin
                lz_sum = lz_sum + 7'(chunk_reg[c]);
            end
            if (chunk_reg[c] != 4'd8)
            begin
                lz_run = 1'b0;
            end
        end
    end

    always_comb
    begin
        pmask        = ~(~SLOT_W'(0) << precision);
        idx_masked   = SLOT_W'(index_in) & pmask;
        rank_cap     = 7'd65 - 7'(precision);
        rank_wide    = 7'(rank_in);
        rank_clamped = (rank_wide > rank_cap) ? RANK_W'(rank_cap) : rank_in;
        if (mixer_select == MIX_MURMUR)
        begin
            k_load = key + 64'd1;
        end
        else if (mixer_select == MIX_WANG)
        begin
            k_load = (~key) + (key << 21);
        end
        else
        begin
            k_load = key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
            ph_reg    <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        unique case (command)
                            CMD_ADD:
                            begin
                                k_reg     <= k_load;
                                step_reg  <= '0;
                                ph_reg    <= '0;
                                state_reg <= F_HASH;
                            end
                            CMD_MERGE:
                            begin
                                slot_reg  <= idx_masked;
                                op_reg    <= '{kind: OP_UPDATE, rank: rank_clamped, bin: '0};
                                state_reg <= F_PUSH;
                            end
                            CMD_READ_REG:
                            begin
                                slot_reg  <= idx_masked;
                                op_reg    <= '{kind: OP_READ_REG, rank: '0, bin: '0};
                                state_reg <= F_PUSH;
                            end
                            CMD_READ_BIN:
                            begin
                                slot_reg  <= '0;
                                op_reg    <= '{kind: OP_READ_BIN, rank: '0, bin: bin};
                                state_reg <= F_PUSH;
                            end
                        endcase
                    end
                end
                F_HASH:
                begin
                    unique case (uop)
                        U_XSR:
                        begin
                            k_reg    <= k_reg ^ (k_reg >> sh);
                            step_reg <= step_reg + 4'd1;
                        end
                        U_XSL:
                        begin
                            k_reg    <= k_reg ^ (k_reg << sh);
                            step_reg <= step_reg + 4'd1;
                        end
                        U_ADDC:
                        begin
                            k_reg    <= k_reg + cst;
                            step_reg <= step_reg + 4'd1;
                        end
                        U_W3_8:
                        begin
                            k_reg    <= (k_reg + (k_reg << 3)) + (k_reg << 8);
                            step_reg <= step_reg + 4'd1;
                        end
                        U_W2_4:
                        begin
                            k_reg    <= (k_reg + (k_reg << 2)) + (k_reg << 4);
                            step_reg <= step_reg + 4'd1;
                        end
                        U_W31:
                        begin
                            k_reg    <= k_reg + (k_reg << 31);
                            step_reg <= step_reg + 4'd1;
                        end
                        U_MUL:
                        begin
                            unique case (ph_reg)
                                2'd0:
                                begin
                                    acc_reg <= prod;
                                    ph_reg  <= 2'd1;
                                end
                                2'd1:
                                begin
                                    acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
                                    ph_reg         <= 2'd2;
                                end
                                default:
                                begin
                                    k_reg    <= {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
                                    ph_reg   <= 2'd0;
                                    step_reg <= step_reg + 4'd1;
                                end
                            endcase
                        end
                        U_DONE:
                        begin
                            rest_reg  <= (k_reg << precision) | ((64'd1 << precision) - 64'd1);
                            slot_reg  <= SLOT_W'(k_reg >> (7'd64 - 7'(precision)));
                            state_reg <= F_LZC1;
                        end
                    endcase
                end
                F_LZC1:
                begin
                    chunk_reg <= chunk_next;
                    state_reg <= F_LZC2;
                end
                F_LZC2:
                begin
                    op_reg    <= '{kind: OP_UPDATE, rank: RANK_W'(lz_sum + 7'd1), bin: '0};
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (push_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign s_tready   = (state_reg == F_IDLE) && !clearing;
    assign push_valid = (state_reg == F_PUSH);
    assign push_op    = op_reg;
    assign push_slot  = slot_reg;

endmodule

@@ rtl/core/hll_queue.sv @@
// Short queue between front end and back end.
module hll_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = hll_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import hll_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slots_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/core/hll_back.sv @@
// Back end: rank register memory, value histogram, clearing sweep and result register.
module hll_back #(
    parameter int MAX_PRECISION = hll_pkg::DEFAULT_MAX_PRECISION
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  hll_pkg::op_t                        q_op,
    input  logic [MAX_PRECISION-1:0]            q_slot,
    input  logic [$clog2(MAX_PRECISION+1)-1:0] precision,
    input  logic                                clear_start,
    output logic                                clearing,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output hll_pkg::result_t                    result
);
    import hll_pkg::*;

    localparam int SLOT_W = MAX_PRECISION;
    localparam int DEPTH  = 1 << SLOT_W;
    localparam int HIST_W = MAX_PRECISION + 1;
    localparam int BINS   = 1 << BIN_W;
    localparam int CLR_W  = (SLOT_W > BIN_W) ? SLOT_W : BIN_W;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_LOOK,
        B_HIST_OLD,
        B_HIST_NEW
    } bstate_t;

    logic [RANK_W-1:0] reg_mem  [DEPTH];
    logic [HIST_W-1:0] hist_mem [BINS];

    bstate_t           state_reg;
    logic [CLR_W-1:0]  clr_addr_reg;
    logic              out_valid_reg;
    result_t           result_reg;
    op_kind_t          cur_kind_reg;
    logic [RANK_W-1:0] cur_rank_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic [RANK_W-1:0] old_reg;
    logic [RANK_W-1:0] reg_rd_reg;
    logic [HIST_W-1:0] hist_rd_reg;

    logic              reg_we;
    logic [SLOT_W-1:0] reg_wa;
    logic [RANK_W-1:0] reg_wd;
    logic [SLOT_W-1:0] reg_ra;
    logic              hist_we;
    logic [BIN_W-1:0]  hist_wa;
    logic [HIST_W-1:0] hist_wd;
    logic [BIN_W-1:0]  hist_ra;
    logic [HIST_W-1:0] bin0_count;

    assign bin0_count = HIST_W'(1) << precision;

    always_comb
    begin
        reg_we  = 1'b0;
        reg_wa  = cur_slot_reg;
        reg_wd  = cur_rank_reg;
        reg_ra  = q_slot;
        hist_we = 1'b0;
        hist_wa = old_reg;
        hist_wd = hist_rd_reg;
        hist_ra = q_op.bin;
        q_ready = 1'b0;
        unique case (state_reg)
            B_CLEAR:
            begin
                reg_we  = ((clr_addr_reg >> SLOT_W) == '0);
                reg_wa  = clr_addr_reg[SLOT_W-1:0];
                reg_wd  = '0;
                hist_we = ((clr_addr_reg >> BIN_W) == '0);
                hist_wa = clr_addr_reg[BIN_W-1:0];
                hist_wd = (clr_addr_reg == '0) ? bin0_count : '0;
            end
            B_IDLE:
            begin
                q_ready = !out_valid_reg && !clear_start;
            end
            B_LOOK:
            begin
                hist_ra = reg_rd_reg;
                reg_we  = (cur_kind_reg == OP_UPDATE) && (cur_rank_reg > reg_rd_reg);
            end
            B_HIST_OLD:
            begin
                hist_we = 1'b1;
                hist_wa = old_reg;
                hist_wd = hist_rd_reg - HIST_W'(hist_rd_reg != '0);
                hist_ra = cur_rank_reg;
            end
            B_HIST_NEW:
            begin
                hist_we = 1'b1;
                hist_wa = cur_rank_reg;
                hist_wd = hist_rd_reg + HIST_W'(1);
            end
            default:
            begin
                q_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (reg_we)
        begin
            reg_mem[reg_wa] <= reg_wd;
        end
        reg_rd_reg <= reg_mem[reg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        hist_rd_reg <= hist_mem[hist_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear_start)
            begin
                state_reg    <= B_CLEAR;
                clr_addr_reg <= '0;
            end
            else
            begin
                unique case (state_reg)
                    B_CLEAR:
                    begin
                        clr_addr_reg <= clr_addr_reg + CLR_W'(1);
                        if (clr_addr_reg == '1)
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                    B_IDLE:
                    begin
                        if (q_valid && q_ready)
                        begin
                            cur_kind_reg <= q_op.kind;
                            cur_rank_reg <= q_op.rank;
                            cur_slot_reg <= q_slot;
                            state_reg    <= B_LOOK;
                        end
                    end
                    B_LOOK:
                    begin
                        unique case (cur_kind_reg)
                            OP_READ_BIN:
                            begin
                                result_reg    <= '{bin_count: BIN_COUNT_W'(hist_rd_reg),
                                                   updated: 1'b0, rank_out: '0, reg_index: '0};
                                out_valid_reg <= 1'b1;
                                state_reg     <= B_IDLE;
                            end
                            OP_READ_REG:
                            begin
                                result_reg    <= '{bin_count: '0, updated: 1'b0,
                                                   rank_out: reg_rd_reg,
                                                   reg_index: INDEX_W'(cur_slot_reg)};
                                out_valid_reg <= 1'b1;
                                state_reg     <= B_IDLE;
                            end
                            default:
                            begin
                                if (cur_rank_reg > reg_rd_reg)
                                begin
                                    old_reg   <= reg_rd_reg;
                                    state_reg <= B_HIST_OLD;
                                end
                                else
                                begin
                                    result_reg    <= '{bin_count: '0, updated: 1'b0,
                                                       rank_out: reg_rd_reg,
                                                       reg_index: INDEX_W'(cur_slot_reg)};
                                    out_valid_reg <= 1'b1;
                                    state_reg     <= B_IDLE;
                                end
                            end
                        endcase
                    end
                    B_HIST_OLD:
                    begin
                        state_reg <= B_HIST_NEW;
                    end
                    B_HIST_NEW:
                    begin
                        result_reg    <= '{bin_count: '0, updated: 1'b1,
                                           rank_out: cur_rank_reg,
                                           reg_index: INDEX_W'(cur_slot_reg)};
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                    default:
                    begin
                        state_reg <= B_IDLE;
                    end
                endcase
            end
        end
    end

    assign clearing = (state_reg == B_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

endmodule

@@ rtl/core/hyperloglog_register_update.sv @@
// Top level of the dense HyperLogLog register update block.
// Front end: merge and read beats skip the mixer; an add steps the wang mixer, the murmur
// finaliser or ranhash, the latter two stepping one shared 32x32 multiplier.
// Back end: ops look up the register or histogram; raising a register also moves one count between bins.
// Reset and every precision write run a clearing sweep over max(2^MAX_PRECISION, 64) addresses;
// s_tready stays low during the sweep, configuration writes are still taken.
module hyperloglog_register_update #(
    parameter int MAX_PRECISION = hll_pkg::DEFAULT_MAX_PRECISION
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [95:0]                        s_tdata,  // key, index_in, rank_in, bin, zero pad
    input  logic [1:0]                         s_tuser,  // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [39:0]                        m_tdata,  // reg_index, rank_out, updated, bin_count, pad
    input  logic                               cfg_wr_en,
    input  logic [hll_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hll_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import hll_pkg::*;

    localparam int SLOT_W     = MAX_PRECISION;
    localparam int PREC_W     = $clog2(MAX_PRECISION + 1);
    localparam int PREC_INIT  = (MAX_PRECISION < PRECISION_RESET) ? MAX_PRECISION : PRECISION_RESET;
    localparam int OP_W       = $bits(op_t);
    localparam int ENTRY_W    = OP_W + SLOT_W;

    logic [PREC_W-1:0]  precision_reg;
    logic [PREC_W-1:0]  precision_next;
    logic [MIXER_W-1:0] mixer_reg;
    logic               clear_start;
    logic               clearing;

    cmd_t               command;
    logic               push_valid;
    logic               push_ready;
    op_t                push_op;
    logic [SLOT_W-1:0]  push_slot;
    logic               q_valid;
    logic               q_ready;
    logic [ENTRY_W-1:0] q_data;
    op_t                q_op;
    logic [SLOT_W-1:0]  q_slot;
    result_t            result;

    always_comb
    begin
        if (cfg_data < CFG_DATA_W'(MIN_PRECISION))
        begin
            precision_next = PREC_W'(MIN_PRECISION);
        end
        else if (int'(cfg_data) > MAX_PRECISION)
        begin
            precision_next = PREC_W'(MAX_PRECISION);
        end
        else
        begin
            precision_next = PREC_W'(cfg_data);
        end
    end

    assign clear_start = cfg_wr_en && (cfg_index == CFG_PRECISION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            precision_reg <= PREC_W'(PREC_INIT);
            mixer_reg     <= MIX_MURMUR;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_PRECISION)
            begin
                precision_reg <= precision_next;
            end
            else if (cfg_index == CFG_MIXER)
            begin
                mixer_reg <= cfg_data[MIXER_W-1:0];
            end
        end
    end

    assign command = cmd_t'(s_tuser);

    hll_front #(
        .MAX_PRECISION (MAX_PRECISION)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .command      (command),
        .key          (s_tdata[63:0]),
        .index_in     (s_tdata[77:64]),
        .rank_in      (s_tdata[83:78]),
        .bin          (s_tdata[89:84]),
        .precision    (precision_reg),
        .mixer_select (mixer_reg),
        .clearing     (clearing),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_op      (push_op),
        .push_slot    (push_slot)
    );

    hll_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_slot, push_op}),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    assign q_op   = op_t'(q_data[OP_W-1:0]);
    assign q_slot = q_data[ENTRY_W-1:OP_W];

    hll_back #(
        .MAX_PRECISION (MAX_PRECISION)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_op        (q_op),
        .q_slot      (q_slot),
        .precision   (precision_reg),
        .clear_start (clear_start),
        .clearing    (clearing),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .result      (result)
    );

    assign m_tdata = {4'b0, result};

    a_updated_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result.updated |-> result.rank_out != '0)
        else $error("raised register reported with rank zero");

    a_count_only_for_bin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result.bin_count != '0 |->
            result.reg_index == '0 && result.rank_out == '0 && !result.updated)
        else $error("bin count reported on a register result");

    a_rank_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 7'(result.rank_out) <= 7'd65 - 7'(precision_reg))
        else $error("register value above rank cap");

    a_clear_on_precision: assert property (@(posedge clk) disable iff (!rst_n)
        clear_start |=> clearing && !s_tready)
        else $error("precision write did not start a clearing sweep");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the dense HyperLogLog register update block.
`timescale 1ns / 1ps

module tb_top;
    import hll_pkg::*;

    localparam int MAX_P          = DEFAULT_MAX_PRECISION;
    localparam int REG_DEPTH      = 1 << MAX_P;
    localparam int HIST_BINS      = 64;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 60000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 116;

    localparam logic [MIXER_W-1:0] MIX_RANHASH = 2'd2;
    localparam logic [MIXER_W-1:0] MIX_SPARE   = 2'd3;

    class hll_scoreboard;
        bit [RANK_W-1:0]    rank_mem [REG_DEPTH];
        int unsigned        bin_hist [HIST_BINS];
        int unsigned        prec;
        logic [MIXER_W-1:0] mixer;
        result_t            expected [$];
        int unsigned        touched [$];
        int                 errors;

        function void clear_sketch();
            foreach (rank_mem[i]) rank_mem[i] = '0;
            foreach (bin_hist[i]) bin_hist[i] = 0;
            bin_hist[0] = 1 << prec;
        endfunction

        function void reset_state();
            prec   = PRECISION_RESET;
            mixer  = MIX_MURMUR;
            errors = 0;
            clear_sketch();
        endfunction

        function void write_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_PRECISION)
            begin
                if (val < MIN_PRECISION)
                    prec = MIN_PRECISION;
                else if (val > MAX_P)
                    prec = MAX_P;
                else
                    prec = val;
                clear_sketch();
            end
            else
            begin
                mixer = val[MIXER_W-1:0];
            end
        endfunction

        function bit [63:0] mix_murmur(bit [63:0] k);
            k = k + 64'd1;
            k ^= k >> 33;
            k = k * MURMUR_C1;
            k ^= k >> 33;
            k = k * MURMUR_C2;
            k ^= k >> 33;
            return k;
        endfunction

        function bit [63:0] mix_wang(bit [63:0] k);
            k = (~k) + (k << 21);
            k ^= k >> 24;
            k = (k + (k << 3)) + (k << 8);
            k ^= k >> 14;
            k = (k + (k << 2)) + (k << 4);
            k ^= k >> 28;
            k = k + (k << 31);
            return k;
        endfunction

        function bit [63:0] mix_ranhash(bit [63:0] u);
            bit [63:0] v;
            v = u * RAN_MUL1 + RAN_ADD;
            v ^= v >> 21;
            v ^= v << 37;
            v ^= v >> 4;
            v = v * RAN_MUL2;
            v ^= v << 20;
            v ^= v >> 41;
            v ^= v << 5;
            return v;
        endfunction

        function int unsigned lead_zeros(bit [63:0] x);
            for (int i = 63; i >= 0; i--)
            begin
                if (x[i])
                    return 63 - i;
            end
            return 64;
        endfunction

        function bit raise_rank(int unsigned slot, int unsigned r);
            int unsigned old;
            old = rank_mem[slot];
            if (r <= old)
                return 1'b0;
            if (bin_hist[old] > 0)
                bin_hist[old]--;
            bin_hist[r % HIST_BINS]++;
            rank_mem[slot] = r[RANK_W-1:0];
            return 1'b1;
        endfunction

        function void note_input(cmd_t cmd, bit [63:0] key, bit [INDEX_W-1:0] idx,
                                 bit [RANK_W-1:0] rank, bit [BIN_W-1:0] bin);
            result_t     res;
            bit [63:0]   h;
            bit [63:0]   rest;
            int unsigned pmask;
            int unsigned slot;
            int unsigned r;
            res   = '0;
            pmask = (1 << prec) - 1;
            slot  = idx & pmask;
            case (cmd)
                CMD_ADD:
                begin
                    case (mixer)
                        MIX_MURMUR: h = mix_murmur(key);
                        MIX_WANG:   h = mix_wang(key);
                        default:    h = mix_ranhash(key);
                    endcase
                    slot = 32'(h >> (64 - prec)) & pmask;
                    rest = (h << prec) | ((64'd1 << prec) - 64'd1);
                    r    = lead_zeros(rest) + 1;
                    res.updated  = raise_rank(slot, r);
                    res.rank_out = rank_mem[slot];
                    res.reg_index = slot[INDEX_W-1:0];
                end
                CMD_MERGE:
                begin
                    r = rank;
                    if (r > 65 - prec)
                        r = 65 - prec;
                    res.updated  = raise_rank(slot, r);
                    res.rank_out = rank_mem[slot];
                    res.reg_index = slot[INDEX_W-1:0];
                end
                CMD_READ_REG:
                begin
                    res.rank_out = rank_mem[slot];
                    res.reg_index = slot[INDEX_W-1:0];
                end
                default:
                begin
                    res.bin_count = bin_hist[bin][BIN_COUNT_W-1:0];
                end
            endcase
            expected.insert(expected.size(), res);
            if (cmd != CMD_READ_BIN)
            begin
                touched.insert(touched.size(), slot);
                if (touched.size() > 32)
                    void'(touched.pop_front());
            end
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_beat(logic [39:0] beat);
            result_t got;
            result_t want;
            got = result_t'(beat[35:0]);
            if (expected.size() == 0)
            begin
                report($sformatf("result beat with nothing outstanding: %h", beat));
                return;
            end
            want = expected.pop_front();
            if (got.reg_index !== want.reg_index)
                report($sformatf("reg_index %0d, want %0d", got.reg_index, want.reg_index));
            if (got.rank_out !== want.rank_out)
                report($sformatf("rank_out %0d, want %0d", got.rank_out, want.rank_out));
            if (got.updated !== want.updated)
                report($sformatf("updated %0b, want %0b", got.updated, want.updated));
            if (got.bin_count !== want.bin_count)
                report($sformatf("bin_count %0d, want %0d", got.bin_count, want.bin_count));
        endtask
    endclass

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [95:0]            s_tdata   = '0;  // key, index_in, rank_in, bin, zero pad
    logic [1:0]             s_tuser   = '0;  // command
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [39:0]            m_tdata;         // reg_index, rank_out, updated, bin_count, pad
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    hll_scoreboard sketch_sb;
    bit            quiet;
    int            idle_cycles;
    bit [63:0]     key_pool [8];

    logic [CFG_DATA_W-1:0] phase_prec  [NUM_PHASES] = '{4'd4, 4'd0, 4'd8, 4'd15,
                                                        4'd6, 4'd6, 4'd3, 4'd10};
    logic [MIXER_W-1:0]    phase_mixer [NUM_PHASES] = '{MIX_WANG, MIX_RANHASH, MIX_SPARE,
                                                        MIX_MURMUR, MIX_MURMUR, MIX_WANG,
                                                        MIX_RANHASH, MIX_SPARE};
    bit                    phase_clear [NUM_PHASES] = '{1, 1, 1, 1, 1, 0, 1, 1};

    hyperloglog_register_update dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(cmd_t cmd, bit [63:0] key, bit [INDEX_W-1:0] idx,
                             bit [RANK_W-1:0] rank, bit [BIN_W-1:0] bin);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, bin, rank, idx, key};
        do
            @(posedge clk);
        while (!s_tready);
        sketch_sb.note_input(cmd, key, idx, rank, bin);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sketch_sb.expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sketch_sb.write_config(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random();
        cmd_t                cmd;
        bit [63:0]           key;
        bit [INDEX_W-1:0]    idx;
        bit [RANK_W-1:0]     rank;
        bit [BIN_W-1:0]      bin;
        int                  roll;
        int unsigned         pmask;
        roll  = $urandom_range(0, 99);
        cmd   = roll < 50 ? CMD_ADD : roll < 70 ? CMD_MERGE : roll < 85 ? CMD_READ_REG
                                                                        : CMD_READ_BIN;
        pmask = (1 << sketch_sb.prec) - 1;

        roll = $urandom_range(0, 99);
        if (roll < 15)
            key = key_pool[$urandom_range(0, 7)];
        else if (roll < 20)
            key = {$urandom_range(0, 1) ? 32'hffff_ffff : 32'h0,
                   $urandom_range(0, 1) ? 32'h1 : 32'h0};
        else
            key = {$urandom, $urandom};

        idx = INDEX_W'($urandom_range(0, REG_DEPTH - 1));
        if (sketch_sb.touched.size() != 0 && $urandom_range(0, 1))
            idx = INDEX_W'((sketch_sb.touched[$urandom_range(0, sketch_sb.touched.size() - 1)]
                            & pmask) | (idx & ~pmask));

        roll = $urandom_range(0, 99);
        if (roll < 35)
            rank = RANK_W'($urandom_range(0, 5));
        else if (roll < 45)
            rank = RANK_W'($urandom_range(50, 63));
        else
            rank = RANK_W'($urandom_range(0, 63));

        bin = BIN_W'($urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 63));
        send_item(cmd, key, idx, rank, bin);
    endtask

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready   <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready   <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sketch_sb.check_beat(m_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** hyperloglog_register_update: FAILED **");
            $finish;
        end
    end

    initial
    begin
        idle_cycles = 0;
        quiet       = 1'b0;
        sketch_sb   = new();
        sketch_sb.reset_state();
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        send_item(CMD_READ_BIN, '0, '0, '0, 6'd0);
        send_item(CMD_READ_BIN, '0, '0, '0, 6'd63);
        send_item(CMD_READ_REG, '0, 14'd0, '0, '0);
        send_item(CMD_READ_REG, '0, 14'h3fff, '0, '0);
        send_item(CMD_ADD, 64'd0, '0, '0, '0);
        send_item(CMD_ADD, '1, '1, '1, '1);
        send_item(CMD_ADD, 64'd0, '0, '0, '0);
        send_item(CMD_ADD, 64'h8000_0000_0000_0000, '0, '0, '0);
        send_item(CMD_MERGE, '0, 14'h3fff, 6'd0, '0);
        send_item(CMD_MERGE, '0, 14'h3fff, 6'd63, '0);
        send_item(CMD_MERGE, '0, 14'h3fff, 6'd61, '0);
        send_item(CMD_MERGE, '0, 14'd0, 6'd1, '0);
        send_item(CMD_MERGE, '0, 14'd0, 6'd1, '0);
        send_item(CMD_MERGE, '0, 14'd0, 6'd0, '0);
        send_item(CMD_READ_REG, '0, 14'h3fff, '0, '0);
        send_item(CMD_READ_REG, '0, 14'd0, '0, '0);
        send_item(CMD_READ_BIN, '0, '0, '0, 6'd51);
        send_item(CMD_READ_BIN, '0, '0, '0, 6'd1);
        send_item(CMD_READ_BIN, '0, '0, '0, 6'd0);
        send_item(CMD_READ_BIN, '0, '0, '0, 6'd63);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            quiet = (ph % 3 == 2);
            if (phase_clear[ph])
                write_reg(CFG_PRECISION, phase_prec[ph]);
            write_reg(CFG_MIXER, CFG_DATA_W'(phase_mixer[ph]));
            if (phase_clear[ph] && sketch_sb.prec <= 6)
            begin
                send_item(CMD_MERGE, '0, '1, '1, '0);
                send_item(CMD_READ_BIN, '0, '0, '0, BIN_W'(65 - sketch_sb.prec));
            end
            repeat (PHASE_ITEMS) send_random();
        end

        drain();
        if (sketch_sb.errors == 0)
            $display("** hyperloglog_register_update: PASSED **");
        else
            $display("** hyperloglog_register_update: FAILED **");
        $finish;
    end

endmodule
